### design/mfd_pkg.sv
// shared constants, types and sine table builder for the modulated fractional delay
`default_nettype none

package mfd_pkg;

  localparam int BUFFER_DEPTH_DEF     = 4096;
  localparam int NUM_CHANNELS_DEF     = 2;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF      = 24;

  localparam int BASE_W     = 20;
  localparam int DEPTH_W    = 18;
  localparam int STEP_W     = 31;
  localparam int RATIO_W    = 16;
  localparam int CFG_DATA_W = 31;
  localparam int PHASE_W    = 32;
  localparam int SINE_W     = 16;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd16384;
  localparam int RATIO_SHIFT = 14;
  localparam int EFF_W       = BASE_W + RATIO_W - RATIO_SHIFT;
  localparam int LFO_SHIFT   = 15;
  localparam int TSUM_W      = 40;
  localparam int FRAC_W      = 8;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 19;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef enum logic [1:0] {
    REG_BASE_DELAY,
    REG_LFO_DEPTH,
    REG_PHASE_STEP,
    REG_STEREO_RATIO
  } cfg_reg_t;

  // pi in Q2.30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam longint unsigned TAYLOR_DIV [1:10] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  // sin(x) for x in Q2.30, result in Q.15 clamped to 0..32768
  function automatic logic [SINE_W-1:0] quarter_sine_val(input logic [63:0] x);
    logic [63:0] t;
    longint      sum;
    t   = x;
    sum = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / TAYLOR_DIV[n];
      if ((n % 2) == 1) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 16384) >>> 15;
    if (sum > 32768) begin
      sum = 32768;
    end
    return SINE_W'(sum);
  endfunction

endpackage

`default_nettype wire

### design/mfd_mul.sv
// shared signed multiplier with registered product
`default_nettype none

module mfd_mul (
  input  logic                                  clk,
  input  logic signed [mfd_pkg::MUL_A_W-1:0]    a,
  input  logic signed [mfd_pkg::MUL_B_W-1:0]    b,
  output logic signed [mfd_pkg::PROD_W-1:0]     prod
);
  import mfd_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

### design/mfd_sine_rom.sv
// quarter-wave sine table with registered read
`default_nettype none

module mfd_sine_rom #(
  parameter int QUARTER_LEN = mfd_pkg::SINE_TABLE_DEPTH_DEF / 4,
  parameter int ROM_AW      = $clog2(QUARTER_LEN + 1)
) (
  input  logic                          clk,
  input  logic [ROM_AW-1:0]             addr,
  output logic [mfd_pkg::SINE_W-1:0]    data
);
  import mfd_pkg::*;

  logic [SINE_W-1:0] tab [QUARTER_LEN+1];

  for (genvar k = 0; k <= QUARTER_LEN; k++) begin : g_tab
    localparam logic [63:0] X = (PI_Q30 * 64'(k)) / (2 * QUARTER_LEN);
    assign tab[k] = quarter_sine_val(X);
  end

  always_ff @(posedge clk) begin
    data <= tab[addr];
  end

endmodule

`default_nettype wire

### design/mfd_delay_mem.sv
// per-channel circular sample store, one write and one registered read port
`default_nettype none

module mfd_delay_mem #(
  parameter int BUFFER_DEPTH = mfd_pkg::BUFFER_DEPTH_DEF,
  parameter int NUM_CHANNELS = mfd_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = mfd_pkg::SAMPLE_BITS_DEF,
  parameter int PTR_W        = $clog2(BUFFER_DEPTH),
  parameter int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [CH_W-1:0]        ch,
  input  logic [PTR_W-1:0]       waddr,
  input  logic [SAMPLE_BITS-1:0] wdata,
  input  logic [PTR_W-1:0]       raddr,
  output logic [SAMPLE_BITS-1:0] rdata
);

  logic [SAMPLE_BITS-1:0] mem [NUM_CHANNELS][BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[ch][waddr] <= wdata;
    end
    rdata <= mem[ch][raddr];
  end

endmodule

`default_nettype wire

### design/modulated_fractional_delay.sv
// top level: lfo-modulated fractional delay line with linear interpolation
//
//   channel   handshake            payload
//   input     in_valid/in_ready    sample_in, chan
//   output    out_valid/out_ready  sample_out
//   config    cfg_we               cfg_index, cfg_data
//
// a delayed transaction steps the sequencer through S_EFF, S_IDX, S_SIN, S_LFO,
// S_TOT, S_PTR, S_RD1, S_RD2, S_MUL2, S_SUM and S_DONE before the next acceptance;
// a bypass transaction (effective delay below one sample) goes from S_IDX to
// S_DONE. the steps follow from one shared multiplier and the single read port
// of the sample store. synchronous reset clears the control state, pointers and
// lfo phases; store entries not yet written read as zero via a per-channel fill
// flag. a result waiting on out_ready holds the sequencer in its final step.
`default_nettype none

module modulated_fractional_delay #(
  parameter int BUFFER_DEPTH     = mfd_pkg::BUFFER_DEPTH_DEF,
  parameter int NUM_CHANNELS     = mfd_pkg::NUM_CHANNELS_DEF,
  parameter int SINE_TABLE_DEPTH = mfd_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = mfd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in,
  input  logic                                 chan,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        sample_out,
  input  logic                                 cfg_we,
  input  mfd_pkg::cfg_reg_t                    cfg_index,
  input  logic [mfd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import mfd_pkg::*;

  localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W       = $clog2(BUFFER_DEPTH);
  localparam int PS_W        = PTR_W + 1;
  localparam int QUARTER_LEN = SINE_TABLE_DEPTH / 4;
  localparam int IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int ROM_AW      = $clog2(QUARTER_LEN + 1);
  localparam int MAX_DELAY   = (BUFFER_DEPTH - 2) * 256;
  localparam int TOT_W       = $clog2(MAX_DELAY + 1);
  localparam int N_W         = TOT_W - FRAC_W;
  localparam int TSH_W       = TSUM_W - 1 - LFO_SHIFT;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EFF,
    S_IDX,
    S_SIN,
    S_LFO,
    S_TOT,
    S_PTR,
    S_RD1,
    S_RD2,
    S_MUL2,
    S_SUM,
    S_DONE
  } state_t;

  // configuration
  logic [BASE_W-1:0]  base_delay;
  logic [DEPTH_W-1:0] lfo_depth;
  logic [STEP_W-1:0]  phase_step;
  logic [RATIO_W-1:0] stereo_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay   <= '0;
      lfo_depth    <= '0;
      phase_step   <= '0;
      stereo_ratio <= RATIO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_DELAY:   base_delay   <= cfg_data[BASE_W-1:0];
        REG_LFO_DEPTH:    lfo_depth    <= cfg_data[DEPTH_W-1:0];
        REG_PHASE_STEP:   phase_step   <= cfg_data[STEP_W-1:0];
        REG_STEREO_RATIO: stereo_ratio <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  state_t                         state;
  logic [CH_W-1:0]                ch;
  logic signed [SAMPLE_BITS-1:0]  sample_q;
  logic [EFF_W-1:0]               eff;
  logic                           neg;
  logic [TOT_W-1:0]               tot;
  logic [PTR_W-1:0]               p1;
  logic [PTR_W-1:0]               p2;
  logic [FRAC_W-1:0]              frac;
  logic                           rd_ok;
  logic signed [PROD_W-1:0]       acc;
  logic signed [SAMPLE_BITS-1:0]  res;
  logic [PTR_W-1:0]               wp    [NUM_CHANNELS];
  logic                           full  [NUM_CHANNELS];
  logic [PHASE_W-1:0]             phase [NUM_CHANNELS];

  logic signed [MUL_A_W-1:0]      mul_a;
  logic signed [MUL_B_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]       prod;
  logic [ROM_AW-1:0]              rom_addr;
  logic [SINE_W-1:0]              rom_data;
  logic                           mem_we;
  logic [PTR_W-1:0]               raddr;
  logic [SAMPLE_BITS-1:0]         rdata;

  logic [CH_W-1:0]                ch_in;
  logic [EFF_W-1:0]               eff_next;
  logic [IDX_W-1:0]               idx;
  logic [IDX_W-1:0]               off;
  logic                           quad_odd;
  logic                           neg_next;
  logic signed [SINE_W:0]         sine_val;
  logic signed [TSUM_W-1:0]       tsum;
  logic [TSH_W-1:0]               tshift;
  logic [TOT_W-1:0]               tot_next;
  logic [N_W-1:0]                 n1;
  logic [PS_W-1:0]                psum;
  logic [PTR_W-1:0]               p1_next;
  logic [PTR_W-1:0]               p2_next;
  logic                           ok_next;
  logic signed [SAMPLE_BITS-1:0]  smp;
  logic signed [PROD_W-1:0]       isum;
  logic [PTR_W-1:0]               wp_inc;

  assign in_ready = (state == S_IDLE);
  assign mem_we   = (state == S_SUM);
  assign ch_in    = (32'(chan) >= NUM_CHANNELS) ? CH_W'(NUM_CHANNELS - 1) : CH_W'(chan);

  // effective delay, channel one scaled by the stereo ratio
  assign eff_next = (ch == CH_W'(1)) ? prod[RATIO_SHIFT +: EFF_W] : EFF_W'(base_delay);

  // quadrant fold of the table index
  always_comb begin
    idx      = prod[PHASE_W +: IDX_W];
    quad_odd = 1'b0;
    neg_next = 1'b0;
    off      = idx;
    if (idx < IDX_W'(QUARTER_LEN)) begin
      off = idx;
    end else if (idx < IDX_W'(2 * QUARTER_LEN)) begin
      off      = idx - IDX_W'(QUARTER_LEN);
      quad_odd = 1'b1;
    end else if (idx < IDX_W'(3 * QUARTER_LEN)) begin
      off      = idx - IDX_W'(2 * QUARTER_LEN);
      neg_next = 1'b1;
    end else begin
      off      = idx - IDX_W'(3 * QUARTER_LEN);
      quad_odd = 1'b1;
      neg_next = 1'b1;
    end
    rom_addr = quad_odd ? ROM_AW'(IDX_W'(QUARTER_LEN) - off) : ROM_AW'(off);
  end

  assign sine_val = neg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

  // total delay with clamp to the buffer range
  always_comb begin
    tsum   = $signed({3'b000, eff, LFO_SHIFT'(0)}) + $signed(prod[TSUM_W-1:0]);
    tshift = tsum[TSUM_W-2:LFO_SHIFT];
    if (tsum[TSUM_W-1]) begin
      tot_next = '0;
    end else if (tshift > TSH_W'(MAX_DELAY)) begin
      tot_next = TOT_W'(MAX_DELAY);
    end else begin
      tot_next = tshift[TOT_W-1:0];
    end
  end

  // tap positions
  always_comb begin
    n1   = tot[TOT_W-1:FRAC_W];
    psum = PS_W'(wp[ch]) + PS_W'(BUFFER_DEPTH) - PS_W'(n1);
    if (psum >= PS_W'(BUFFER_DEPTH)) begin
      p1_next = PTR_W'(psum - PS_W'(BUFFER_DEPTH));
    end else begin
      p1_next = PTR_W'(psum);
    end
    p2_next = (p1_next == '0) ? PTR_W'(BUFFER_DEPTH - 1) : p1_next - PTR_W'(1);
  end

  assign raddr   = (state == S_RD2) ? p2 : p1;
  assign ok_next = full[ch] || (raddr < wp[ch]);
  assign smp     = rd_ok ? $signed(rdata) : '0;
  assign isum    = acc + prod;
  assign wp_inc  = (wp[ch] == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wp[ch] + PTR_W'(1);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_EFF: begin
        mul_a = MUL_A_W'(base_delay);
        mul_b = MUL_B_W'(stereo_ratio);
      end
      S_IDX: begin
        mul_a = MUL_A_W'(phase[ch]);
        mul_b = MUL_B_W'(SINE_TABLE_DEPTH);
      end
      S_LFO: begin
        mul_a = MUL_A_W'(sine_val);
        mul_b = MUL_B_W'(lfo_depth);
      end
      S_RD2: begin
        mul_a = MUL_A_W'(smp);
        mul_b = MUL_B_W'(9'd256 - 9'(frac));
      end
      S_MUL2: begin
        mul_a = MUL_A_W'(smp);
        mul_b = MUL_B_W'(frac);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wp[i]    <= '0;
        full[i]  <= 1'b0;
        phase[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_q <= sample_in;
            ch       <= ch_in;
            state    <= S_EFF;
          end
        end
        S_EFF: state <= S_IDX;
        S_IDX: begin
          eff <= eff_next;
          if (eff_next < EFF_W'(256)) begin
            res   <= sample_q;
            state <= S_DONE;
          end else begin
            state <= S_SIN;
          end
        end
        S_SIN: begin
          neg   <= neg_next;
          state <= S_LFO;
        end
        S_LFO: state <= S_TOT;
        S_TOT: begin
          tot   <= tot_next;
          state <= S_PTR;
        end
        S_PTR: begin
          p1    <= p1_next;
          p2    <= p2_next;
          frac  <= tot[FRAC_W-1:0];
          state <= S_RD1;
        end
        S_RD1: begin
          rd_ok <= ok_next;
          state <= S_RD2;
        end
        S_RD2: begin
          rd_ok <= ok_next;
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= prod;
          state <= S_SUM;
        end
        S_SUM: begin
          res       <= isum[SAMPLE_BITS+FRAC_W-1:FRAC_W];
          wp[ch]    <= wp_inc;
          phase[ch] <= phase[ch] + PHASE_W'(phase_step);
          if (wp_inc == '0) begin
            full[ch] <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            sample_out <= res;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mfd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  mfd_sine_rom #(
    .QUARTER_LEN (QUARTER_LEN),
    .ROM_AW      (ROM_AW)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  mfd_delay_mem #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .PTR_W        (PTR_W),
    .CH_W         (CH_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .ch    (ch),
    .waddr (wp[ch]),
    .wdata (sample_q),
    .raddr (raddr),
    .rdata (rdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted transaction did not make the block busy");

  a_tot_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PTR) |-> (tot <= TOT_W'(MAX_DELAY)))
    else $error("total delay outside buffer range");

  a_pointer_advances: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> ((state == S_DONE) && (wp[ch] != $past(wp[ch]))))
    else $error("store write without pointer advance");

endmodule

`default_nettype wire
